@@ hw/rtl/gfau_pkg.sv @@
// gfau_pkg: opcodes, stage word type and GF(2^8) helper functions
// for the AES field (reduction polynomial 0x11B). No dependencies.
`default_nettype none

package gfau_pkg;

	localparam logic [8:0] GF_POLY    = 9'h11B;
	localparam logic [7:0] GF_INV_EXP = 8'd254;
	localparam int unsigned N_STAGES  = 8;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_POW = 2'd2,
		OP_INV = 2'd3
	} gfau_op_t;

	// one word in flight: running product, running square, exponent bits left
	typedef struct packed {
		logic       vld;
		logic [7:0] acc;
		logic [7:0] sq;
		logic [7:0] ebits;
	} gfau_word_t;

	function automatic logic [7:0] gf_xtime(input logic [7:0] v);
		logic [8:0] t;
		t = {v, 1'b0};
		if (t[8]) begin
			t = t ^ GF_POLY;
		end
		return t[7:0];
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = x;
		for (int i = 0; i < 8; i++) begin
			if (y[i]) begin
				acc = acc ^ sh;
			end
			sh = gf_xtime(sh);
		end
		return acc;
	endfunction

endpackage : gfau_pkg

`default_nettype wire

@@ hw/rtl/gfau_stage.sv @@
// gfau_stage: one square-and-multiply step on exponent bit 0, registered.
// Depends on gfau_pkg.
`default_nettype none

module gfau_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gfau_pkg::gfau_word_t din,
	output gfau_pkg::gfau_word_t    dout
);
	import gfau_pkg::*;

	logic       vld_q;
	logic [7:0] acc_q;
	logic [7:0] sq_q;
	logic [7:0] ebits_q;
	logic [7:0] acc_nxt;

	assign acc_nxt = din.ebits[0] ? gf_mul(din.acc, din.sq) : din.acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		acc_q   <= acc_nxt;
		sq_q    <= gf_mul(din.sq, din.sq);
		ebits_q <= {1'b0, din.ebits[7:1]};
	end

	assign dout = '{vld: vld_q, acc: acc_q, sq: sq_q, ebits: ebits_q};

endmodule : gfau_stage

`default_nettype wire

@@ hw/rtl/gf256_arithmetic_unit.sv @@
// gf256_arithmetic_unit: pipelined GF(2^8) add, multiply, power and inverse.
// Depends on gfau_pkg and gfau_stage.
//
// channel   dir  signals                                     transfer
// command   in   start, busy, opcode, operand_a/b, exponent  start && !busy
// result    out  done, result                                done, one cycle
//
// One word enters every cycle; busy stays low.
// Eight registered square-and-multiply stages, one per exponent bit.
// Multiply runs as a single step, add passes through untouched.
// Reset clears the valid bits only; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module gf256_arithmetic_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] operand_a,
	input  wire logic [7:0] operand_b,
	input  wire logic [7:0] exponent,
	output logic            done,
	output logic [7:0]      result
);
	import gfau_pkg::*;

	gfau_word_t entry;
	gfau_word_t word_s [0:N_STAGES];

	assign busy = 1'b0;

	always_comb begin
		entry.vld = start && !busy;
		unique case (gfau_op_t'(opcode))
			OP_ADD: begin
				entry.acc   = operand_a ^ operand_b;
				entry.sq    = 8'h00;
				entry.ebits = 8'h00;
			end
			OP_MUL: begin
				entry.acc   = operand_a;
				entry.sq    = operand_b;
				entry.ebits = 8'h01;
			end
			OP_POW: begin
				entry.acc   = 8'h01;
				entry.sq    = operand_a;
				entry.ebits = exponent;
			end
			OP_INV: begin
				entry.acc   = 8'h01;
				entry.sq    = operand_a;
				entry.ebits = GF_INV_EXP;
			end
			default: begin
				entry.acc   = 8'h00;
				entry.sq    = 8'h00;
				entry.ebits = 8'h00;
			end
		endcase
	end

	assign word_s[0] = entry;

	for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
		gfau_stage u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (word_s[g]),
			.dout  (word_s[g+1])
		);
	end

	assign done   = word_s[N_STAGES].vld;
	assign result = word_s[N_STAGES].acc;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("accepted word did not emerge after 8 cycles");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 8))
		else $error("result strobe without a matching command");

	a_add: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_ADD) |-> ##8
		(result == $past(operand_a ^ operand_b, 8)))
		else $error("add result mismatch");

	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_INV) |-> ##8
		(($past(operand_a, 8) == 8'h00 && result == 8'h00) ||
		 gf_mul(result, $past(operand_a, 8)) == 8'h01))
		else $error("inverse result mismatch");

endmodule : gf256_arithmetic_unit

`default_nettype wire

@@ bench/gf256_arithmetic_unit_tb.sv @@
// gf256_arithmetic_unit_tb: self-checking bench for the GF(2^8) arithmetic unit,
// bursty command driver, strobe monitor and a bit-level field predictor.
// Depends on gfau_pkg and gf256_arithmetic_unit.
`timescale 1ns / 100ps

module gf256_arithmetic_unit_tb;

	import gfau_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int N_RANDOM    = 550;
	localparam int DRAIN_WAIT  = 24;
	localparam int IDLE_LIMIT  = 2000;

	typedef struct {
		gfau_op_t   op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] e;
	} gf_cmd_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] opcode    = OP_ADD;
	logic [7:0] operand_a = 8'h00;
	logic [7:0] operand_b = 8'h00;
	logic [7:0] exponent  = 8'h00;
	logic       busy;
	logic       done;
	logic [7:0] result;

	gf_cmd_t    cmd_words[$];
	logic [7:0] field_results[$];
	int         errors      = 0;
	int         burst_left  = 0;
	int         gap_left    = 0;
	int         idle_cycles = 0;

	gf256_arithmetic_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.exponent  (exponent),
		.done      (done),
		.result    (result)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] prod;
		logic [7:0] part;
		prod = 8'h00;
		part = x;
		for (int k = 0; k < 8; k++) begin
			if (y[k]) begin
				prod = prod ^ part;
			end
			part = part[7] ? ({part[6:0], 1'b0} ^ GF_POLY[7:0]) : {part[6:0], 1'b0};
		end
		return prod;
	endfunction

	function automatic logic [7:0] gf_raise(input logic [7:0] base, input logic [7:0] e);
		logic [7:0] acc;
		logic [7:0] sq;
		acc = 8'h01;
		sq  = base;
		for (int k = 0; k < 8; k++) begin
			if (e[k]) begin
				acc = gf_times(acc, sq);
			end
			sq = gf_times(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [7:0] gf_evaluate(input gf_cmd_t c);
		case (c.op)
			OP_ADD:  return c.a ^ c.b;
			OP_MUL:  return gf_times(c.a, c.b);
			OP_POW:  return gf_raise(c.a, c.e);
			default: return gf_raise(c.a, GF_INV_EXP);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_cmd(input gfau_op_t op, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] e);
		gf_cmd_t c;
		c.op = op;
		c.a  = a;
		c.b  = b;
		c.e  = e;
		cmd_words.insert(cmd_words.size(), c);
	endtask

	// driver: bursts of words with random gaps; an offered word is held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				field_results.insert(field_results.size(), gf_evaluate(cmd_words[0]));
				void'(cmd_words.pop_front());
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start    <= 1'b0;
				end else if (cmd_words.size() > 0 && !(start && !busy && cmd_words.size() == 0))
						begin
					opcode    <= cmd_words[0].op;
					operand_a <= cmd_words[0].a;
					operand_b <= cmd_words[0].b;
					exponent  <= cmd_words[0].e;
					start     <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [7:0] want;
		if (arst_n && done) begin
			if (field_results.size() == 0) begin
				$display("%0t: unexpected word, expected none actual %02h", $time, result);
				errors++;
			end else begin
				want = field_results.pop_front();
				if (result !== want) begin
					$display("%0t: result expected %02h actual %02h", $time, want, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("gf256_arithmetic_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		// extremes, inverse pairs, reduction carry, zero exponent, inverse of zero
		add_cmd(OP_ADD, 8'h00, 8'h00, 8'hFF);
		add_cmd(OP_ADD, 8'hFF, 8'hFF, 8'h00);
		add_cmd(OP_ADD, 8'hA5, 8'h5A, 8'h3C);
		add_cmd(OP_MUL, 8'h00, 8'hFF, 8'hFF);
		add_cmd(OP_MUL, 8'h01, 8'hFF, 8'h00);
		add_cmd(OP_MUL, 8'hFF, 8'hFF, 8'hAA);
		add_cmd(OP_MUL, 8'h53, 8'hCA, 8'h55);
		add_cmd(OP_MUL, 8'h80, 8'h02, 8'h00);
		add_cmd(OP_MUL, 8'h57, 8'h83, 8'h01);
		add_cmd(OP_POW, 8'h00, 8'hFF, 8'h00);
		add_cmd(OP_POW, 8'hFF, 8'h00, 8'h00);
		add_cmd(OP_POW, 8'h00, 8'h12, 8'h05);
		add_cmd(OP_POW, 8'h03, 8'h00, 8'hFF);
		add_cmd(OP_POW, 8'h02, 8'hFF, 8'hFE);
		add_cmd(OP_POW, 8'h53, 8'h77, 8'h01);
		add_cmd(OP_POW, 8'hFF, 8'hFF, 8'hFF);
		add_cmd(OP_INV, 8'h00, 8'hFF, 8'hFF);
		add_cmd(OP_INV, 8'h01, 8'h00, 8'h00);
		add_cmd(OP_INV, 8'h53, 8'hA5, 8'h5A);
		add_cmd(OP_INV, 8'hFF, 8'h3C, 8'hC3);
		add_cmd(OP_INV, 8'h80, 8'h01, 8'h80);
		for (int n = 0; n < N_RANDOM; n++) begin
			add_cmd(gfau_op_t'($urandom_range(0, 3)), pick_byte(), pick_byte(), pick_byte());
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_words.size() > 0 || field_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (field_results.size() > 0) begin
			$display("%0t: words outstanding, expected 0 actual %0d", $time,
					field_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("gf256_arithmetic_unit: match");
		end else begin
			$display("gf256_arithmetic_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/gfau_pkg.sv
hw/rtl/gfau_stage.sv
hw/rtl/gf256_arithmetic_unit.sv
bench/gf256_arithmetic_unit_tb.sv
